### src/lzssd_pkg.sv
// ----------------------------------------------------------------------------
// lzssd_pkg
// Shared constants, status codes and controller/datapath interface types of
// the LZSS ring decompressor.
// ----------------------------------------------------------------------------
package lzssd_pkg;

    localparam int RING_DEPTH = 2048;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_TRAILING  = 3'd4;

    typedef struct packed {
        logic load;
        logic parse;
        logic lit;
        logic rd;
        logic wr;
        logic stat;
    } t_cmd;

    typedef struct packed {
        logic work_lit;
        logic work_copy;
        logic last;
        logic slot_free;
        logic copy_end;
    } t_sts;

endpackage

### src/lzss_ring_decompressor.sv
// ----------------------------------------------------------------------------
// lzss_ring_decompressor
// LZSS stream decoder with header check, 2048-byte history ring and an
// end-of-stream status word.
//
//   channel   dir  words                      fields (low bit up)
//   s_axis    in   one compressed byte        tdata: in_byte; tlast: in_last
//   m_axis    out  data byte or status        tdata: out_byte, status,
//                                             total_written, pad; tuser:
//                                             is_status; tlast: run_last
//   i_cfg_*   in   max_output_size write      32-bit data, write enable
//
// Every word is loaded and parsed; a literal word is then also emitted.
// A token high word then copies each byte with one ring read and one ring
// write, reading each copied byte before writing it back.
// The final word is followed by the status word.
// No clearing pass: ring entries at or above the fill count read as zero.
// A stalled output holds the sequencer; input is taken only between words.
// ----------------------------------------------------------------------------
module lzss_ring_decompressor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // out_byte, status, total_written, zero pad
    output logic [0:0]  m_axis_tuser,  // is_status
    output logic        m_axis_tlast,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data
);

    import lzssd_pkg::*;

    t_cmd        w_cmd;
    t_sts        w_sts;
    logic [7:0]  w_out_byte;
    logic        w_is_status;
    logic [2:0]  w_status;
    logic [31:0] w_total;

    lzssd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lzssd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_byte       (s_axis_tdata),
        .i_in_last       (s_axis_tlast),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_m_tready      (m_axis_tready),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_m_tvalid      (m_axis_tvalid),
        .o_out_byte      (w_out_byte),
        .o_is_status     (w_is_status),
        .o_run_last      (m_axis_tlast),
        .o_status        (w_status),
        .o_total_written (w_total)
    );

    assign m_axis_tdata = {5'd0, w_total, w_status, w_out_byte};
    assign m_axis_tuser = w_is_status;

endmodule

### src/lzssd_ram.sv
// ----------------------------------------------------------------------------
// lzssd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lzssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/lzssd_ctrl.sv
// ----------------------------------------------------------------------------
// lzssd_ctrl
// Sequencer: takes one input word, parses it, then emits a literal, walks a
// ring copy or does neither; after the last word it sends the end-of-stream status.
// ----------------------------------------------------------------------------
module lzssd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  lzssd_pkg::t_sts i_sts,
    output lzssd_pkg::t_cmd o_cmd
);

    import lzssd_pkg::*;

    typedef enum logic [5:0] {
        S_IN    = 6'b000001,
        S_PARSE = 6'b000010,
        S_LIT   = 6'b000100,
        S_RD    = 6'b001000,
        S_WR    = 6'b010000,
        S_STAT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state w_after;

    assign w_after = i_sts.last ? S_STAT : S_IN;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IN: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PARSE;
                end
            end
            S_PARSE: begin
                o_cmd.parse = 1'b1;
                priority if (i_sts.work_lit) begin
                    n_state = S_LIT;
                end else if (i_sts.work_copy) begin
                    n_state = S_RD;
                end else begin
                    n_state = w_after;
                end
            end
            S_LIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.lit = 1'b1;
                    n_state   = w_after;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WR;
            end
            S_WR: begin
                if (i_sts.slot_free) begin
                    o_cmd.wr = 1'b1;
                    n_state  = i_sts.copy_end ? w_after : S_RD;
                end
            end
            S_STAT: begin
                if (i_sts.slot_free) begin
                    o_cmd.stat = 1'b1;
                    n_state    = S_IN;
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IN);

endmodule

### src/lzssd_dp.sv
// ----------------------------------------------------------------------------
// lzssd_dp
// Datapath: stream parser registers, history ring, copy engine and the
// output register.
// ----------------------------------------------------------------------------
module lzssd_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_in_byte,
    input  logic          i_in_last,
    input  logic          i_cfg_wr_en,
    input  logic [31:0]   i_cfg_wr_data,
    input  logic          i_m_tready,
    input  lzssd_pkg::t_cmd i_cmd,
    output lzssd_pkg::t_sts o_sts,
    output logic          o_m_tvalid,
    output logic [7:0]    o_out_byte,
    output logic          o_is_status,
    output logic          o_run_last,
    output logic [2:0]    o_status,
    output logic [31:0]   o_total_written
);

    import lzssd_pkg::*;

    typedef enum logic [6:0] {
        PH_HEADER = 7'b0000001,
        PH_FLAG   = 7'b0000010,
        PH_LIT    = 7'b0000100,
        PH_TOKLO  = 7'b0001000,
        PH_TOKHI  = 7'b0010000,
        PH_DONE   = 7'b0100000,
        PH_ERR    = 7'b1000000
    } t_phase;

    localparam logic [7:0] MAGIC [4] = '{8'h4C, 8'h5A, 8'h53, 8'h53};

    function automatic t_phase f_next(logic at_end, logic [3:0] bit_idx, logic [7:0] flag);
        if (at_end) begin
            return PH_DONE;
        end else if (bit_idx[3]) begin
            return PH_FLAG;
        end else if (flag[~bit_idx[2:0]]) begin
            return PH_LIT;
        end else begin
            return PH_TOKLO;
        end
    endfunction

    // stream state
    t_phase      r_phase, n_phase;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic [31:0] r_decl, n_decl;
    logic [31:0] r_outcnt, n_outcnt;
    logic [3:0]  r_bit, n_bit;
    logic [2:0]  r_err, n_err;
    logic [31:0] r_max;
    logic        r_last, n_last;
    logic        r_o_valid, n_o_valid;

    // payload
    logic [7:0]         r_byte, n_byte;
    logic [7:0]         r_flag, n_flag;
    logic [7:0]         r_toklo, n_toklo;
    logic [RING_AW-1:0] r_pos, n_pos;
    logic [5:0]         r_cnt, n_cnt;
    logic               r_rd_ok, n_rd_ok;
    logic [7:0]         r_o_byte, n_o_byte;
    logic               r_o_is_status, n_o_is_status;
    logic               r_o_run_last, n_o_run_last;
    logic [2:0]         r_o_status, n_o_status;
    logic [31:0]        r_o_total, n_o_total;

    logic [31:0]        w_decl;
    logic [31:0]        w_outcnt_inc;
    logic [3:0]         w_bit_inc;
    logic               w_copy_end;
    logic [7:0]         w_ram_q;
    logic [7:0]         w_copy_byte;
    logic               w_ram_we;
    logic [7:0]         w_ram_wdata;
    logic               w_slot_free;

    assign w_outcnt_inc = r_outcnt + 32'd1;
    assign w_bit_inc    = r_bit + 4'd1;
    assign w_copy_end   = (r_cnt == 6'd1) || (w_outcnt_inc == r_decl);
    assign w_copy_byte  = r_rd_ok ? w_ram_q : 8'd0;
    assign w_slot_free  = !r_o_valid || i_m_tready;

    always_comb begin
        w_decl = r_decl;
        w_decl[{r_hdr_cnt[1:0], 3'b000} +: 8] = r_byte;
    end

    always_comb begin
        n_phase       = r_phase;
        n_hdr_cnt     = r_hdr_cnt;
        n_decl        = r_decl;
        n_outcnt      = r_outcnt;
        n_bit         = r_bit;
        n_err         = r_err;
        n_last        = r_last;
        n_byte        = r_byte;
        n_flag        = r_flag;
        n_toklo       = r_toklo;
        n_pos         = r_pos;
        n_cnt         = r_cnt;
        n_rd_ok       = r_rd_ok;
        n_o_byte      = r_o_byte;
        n_o_is_status = r_o_is_status;
        n_o_run_last  = r_o_run_last;
        n_o_status    = r_o_status;
        n_o_total     = r_o_total;
        n_o_valid     = i_m_tready ? 1'b0 : r_o_valid;
        w_ram_we      = 1'b0;
        w_ram_wdata   = r_byte;

        if (i_cmd.load) begin
            n_byte = i_in_byte;
            n_last = i_in_last;
        end

        if (i_cmd.parse) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (!r_hdr_cnt[2]) begin
                        if (r_byte != MAGIC[r_hdr_cnt[1:0]]) begin
                            n_err   = ST_BAD_MAGIC;
                            n_phase = PH_ERR;
                        end else begin
                            n_hdr_cnt = r_hdr_cnt + 3'd1;
                        end
                    end else begin
                        n_decl    = w_decl;
                        n_hdr_cnt = r_hdr_cnt + 3'd1;
                        if (r_hdr_cnt == 3'd7) begin
                            priority if (w_decl > r_max) begin
                                n_err   = ST_TOO_LARGE;
                                n_phase = PH_ERR;
                            end else if (w_decl == 32'd0) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_phase = PH_FLAG;
                            end
                        end
                    end
                end
                PH_FLAG: begin
                    n_flag  = r_byte;
                    n_bit   = 4'd0;
                    n_phase = f_next(r_outcnt == r_decl, 4'd0, r_byte);
                end
                PH_TOKLO: begin
                    n_toklo = r_byte;
                    n_phase = PH_TOKHI;
                end
                PH_TOKHI: begin
                    n_pos = {r_byte, r_toklo[7:5]};
                    n_cnt = {1'b0, r_toklo[4:0]} + 6'd2;
                end
                PH_DONE: begin
                    n_err   = ST_TRAILING;
                    n_phase = PH_ERR;
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.lit) begin
            n_o_valid     = 1'b1;
            n_o_byte      = r_byte;
            n_o_is_status = 1'b0;
            n_o_run_last  = !r_last;
            n_o_status    = ST_OK;
            n_o_total     = 32'd0;
            w_ram_we      = 1'b1;
            w_ram_wdata   = r_byte;
            n_outcnt      = w_outcnt_inc;
            n_bit         = w_bit_inc;
            n_phase       = f_next(w_outcnt_inc == r_decl, w_bit_inc, r_flag);
        end

        if (i_cmd.rd) begin
            n_rd_ok = (r_outcnt[31:RING_AW] != '0) || (r_pos < r_outcnt[RING_AW-1:0]);
            n_pos   = r_pos + 1'b1;
        end

        if (i_cmd.wr) begin
            n_o_valid     = 1'b1;
            n_o_byte      = w_copy_byte;
            n_o_is_status = 1'b0;
            n_o_run_last  = w_copy_end && !r_last;
            n_o_status    = ST_OK;
            n_o_total     = 32'd0;
            w_ram_we      = 1'b1;
            w_ram_wdata   = w_copy_byte;
            n_outcnt      = w_outcnt_inc;
            n_cnt         = r_cnt - 6'd1;
            if (w_copy_end) begin
                n_bit   = w_bit_inc;
                n_phase = f_next(w_outcnt_inc == r_decl, w_bit_inc, r_flag);
            end
        end

        if (i_cmd.stat) begin
            n_o_valid     = 1'b1;
            n_o_byte      = 8'd0;
            n_o_is_status = 1'b1;
            n_o_run_last  = 1'b1;
            n_o_total     = r_outcnt;
            unique case (r_phase)
                PH_ERR:  n_o_status = r_err;
                PH_DONE: n_o_status = ST_OK;
                default: n_o_status = ST_TRUNCATED;
            endcase
            n_phase   = PH_HEADER;
            n_hdr_cnt = 3'd0;
            n_decl    = 32'd0;
            n_outcnt  = 32'd0;
            n_bit     = 4'd8;
            n_err     = ST_OK;
            n_flag    = 8'd0;
            n_toklo   = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= 3'd0;
            r_decl    <= 32'd0;
            r_outcnt  <= 32'd0;
            r_bit     <= 4'd8;
            r_err     <= ST_OK;
            r_max     <= 32'hFFFF_FFFF;
            r_last    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_decl    <= n_decl;
            r_outcnt  <= n_outcnt;
            r_bit     <= n_bit;
            r_err     <= n_err;
            r_last    <= n_last;
            r_o_valid <= n_o_valid;
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte        <= n_byte;
        r_flag        <= n_flag;
        r_toklo       <= n_toklo;
        r_pos         <= n_pos;
        r_cnt         <= n_cnt;
        r_rd_ok       <= n_rd_ok;
        r_o_byte      <= n_o_byte;
        r_o_is_status <= n_o_is_status;
        r_o_run_last  <= n_o_run_last;
        r_o_status    <= n_o_status;
        r_o_total     <= n_o_total;
    end

    lzssd_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_outcnt[RING_AW-1:0]),
        .i_wdata (w_ram_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_pos),
        .o_rdata (w_ram_q)
    );

    assign o_sts.work_lit  = (r_phase == PH_LIT);
    assign o_sts.work_copy = (r_phase == PH_TOKHI);
    assign o_sts.last      = r_last;
    assign o_sts.slot_free = w_slot_free;
    assign o_sts.copy_end  = w_copy_end;

    assign o_m_tvalid      = r_o_valid;
    assign o_out_byte      = r_o_byte;
    assign o_is_status     = r_o_is_status;
    assign o_run_last      = r_o_run_last;
    assign o_status        = r_o_status;
    assign o_total_written = r_o_total;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.lit || i_cmd.wr || i_cmd.stat) |-> w_slot_free)
        else $error("output register overwritten while full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outcnt <= r_decl)
        else $error("output count passed declared size");

    a_copy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (r_cnt != 6'd0))
        else $error("ring read with no copy length left");

    a_stream_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.stat |=> (r_outcnt == 32'd0) && (r_phase == PH_HEADER))
        else $error("stream state not cleared after status");

endmodule
